@@ hdl/text_console_writer_macros.svh @@
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property wrappers, clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Sizes, codes, sequencer states and divider handshake types.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 64;
    localparam int TAB_WIDTH   = 8;
    localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;

    localparam int ADDR_W = $clog2(STORE_CELLS);
    localparam int SIZE_W = $clog2(STORE_CELLS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int DIV_CNT_W = $clog2(ADDR_W + 1);

    // Port field widths.
    localparam int CMD_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int COLUMN_W   = 7;
    localparam int ROWIN_W    = 6;
    localparam int POS_W      = 13;
    localparam int ATTR_W     = 8;
    localparam int CURSOR_W   = 13;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int CFG_COLS_W = 8;
    localparam int CFG_ROWS_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_COLS_W-1:0] RESET_COLS = CFG_COLS_W'(80);
    localparam logic [CFG_ROWS_W-1:0] RESET_ROWS = CFG_ROWS_W'(25);
    localparam logic [ATTR_W-1:0]     RESET_ATTR = 8'h07;
    localparam logic [CHAR_W-1:0]     SPACE_CHAR = 8'h20;
    localparam logic [CELL_W-1:0]     BLANK_CELL = {RESET_ATTR, SPACE_CHAR};

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

    localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOCATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SETPOS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SETATTR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLAMP,
        ST_EXEC,
        ST_DIV_WAIT,
        ST_RD_DATA,
        ST_POST,
        ST_SC_RD,
        ST_SC_WR,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [COL_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ADDR_W-1:0] quot;
        logic [COL_W-1:0]  rem;
    } t_div_rsp;

endpackage

@@ hdl/tcw_ifs.sv @@
// ----------------------------------------------------------------------------
// Text console writer channels
// Command, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tcw_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CMD_W-1:0]     command;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::COLUMN_W-1:0]  column;
    logic [tcw_pkg::ROWIN_W-1:0]   row;
    logic [tcw_pkg::POS_W-1:0]     position;
    logic [tcw_pkg::ATTR_W-1:0]    attribute;

    modport source (output valid, command, char_code, column, row, position, attribute,
                    input ready);
    modport sink   (input valid, command, char_code, column, row, position, attribute,
                    output ready);
endinterface

interface tcw_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CURSOR_W-1:0]  cursor_pos;
    logic [tcw_pkg::CHAR_W-1:0]    cell_char;
    logic [tcw_pkg::ATTR_W-1:0]    cell_attr;

    modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

interface tcw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::CFG_IDX_W-1:0]  index;
    logic [tcw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tcw_div.sv @@
// ----------------------------------------------------------------------------
// Text console writer divider
// Restoring divider, one quotient bit per cycle: cursor by column count.
// ----------------------------------------------------------------------------
module tcw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcw_pkg::t_div_req i_req,
    output tcw_pkg::t_div_rsp o_rsp
);

    logic [tcw_pkg::ADDR_W-1:0]    r_quot;
    logic [tcw_pkg::COL_W-1:0]     r_rem;
    logic [tcw_pkg::COL_W-1:0]     r_divs;
    logic [tcw_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [tcw_pkg::COL_W:0] w_shift;
    logic [tcw_pkg::COL_W:0] w_diff;
    logic                    w_ge;

    assign w_shift = {r_rem, r_quot[tcw_pkg::ADDR_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_divs});
    assign w_diff  = w_shift - {1'b0, r_divs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= tcw_pkg::DIV_CNT_W'(tcw_pkg::ADDR_W);
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_divs <= i_req.divisor;
            end else if (r_busy) begin
                // The remainder stays below the divisor, so it fits COL_W bits.
                r_rem  <= w_ge ? w_diff[tcw_pkg::COL_W-1:0] : w_shift[tcw_pkg::COL_W-1:0];
                r_quot <= {r_quot[tcw_pkg::ADDR_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == tcw_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

@@ hdl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// Text console writer
// Teletype console: cursor, current attribute and a cell store, with scroll.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       word
//  i_in     in   valid / ready   command, char_code, column, row, position, attribute
//  o_out    out  valid / ready   cursor_pos, cell_char, cell_attr
//  i_cfg    in   valid / ready   index, data (0 columns, 1 rows); always ready
//
// After reset a clearing pass writes every store cell (MAX_COLS * MAX_ROWS),
// during which no word is accepted. Each command passes through ST_CLAMP,
// ST_EXEC and ST_DONE; newline and carriage return also wait on the
// iterative divider (one quotient bit per cycle).
// A scroll copies each cell through a read state and a write state, then blanks the last row.
// A new word is accepted while the last result waits on o_out; a finished
// result then waits until the output register is free.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module text_console_writer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out,
    tcw_cfg_if.sink   i_cfg
);

    localparam int PROD_W = tcw_pkg::ROW_W + tcw_pkg::COL_W;
    localparam int NL_W   = tcw_pkg::ADDR_W + 1 + tcw_pkg::COL_W;

    tcw_pkg::t_state r_state, n_state;

    logic [tcw_pkg::CFG_COLS_W-1:0] r_columns;
    logic [tcw_pkg::CFG_ROWS_W-1:0] r_rows;
    logic [tcw_pkg::SIZE_W-1:0]     r_size;
    logic [tcw_pkg::SIZE_W-1:0]     r_cursor, n_cursor;
    logic [tcw_pkg::ATTR_W-1:0]     r_attr, n_attr;
    logic [tcw_pkg::SIZE_W-1:0]     r_idx, n_idx;
    logic                           r_out_valid, n_out_valid;

    // Captured command word.
    logic [tcw_pkg::CMD_W-1:0]    r_cmd;
    logic [tcw_pkg::CHAR_W-1:0]   r_char;
    logic [tcw_pkg::COLUMN_W-1:0] r_col;
    logic [tcw_pkg::ROWIN_W-1:0]  r_row;
    logic [tcw_pkg::POS_W-1:0]    r_pos;
    logic [tcw_pkg::ATTR_W-1:0]   r_attr_in;

    logic [tcw_pkg::CHAR_W-1:0]   r_rd_char, n_rd_char;
    logic [tcw_pkg::ATTR_W-1:0]   r_rd_attr, n_rd_attr;
    logic [tcw_pkg::CURSOR_W-1:0] r_out_cursor, n_out_cursor;
    logic [tcw_pkg::CHAR_W-1:0]   r_out_char, n_out_char;
    logic [tcw_pkg::ATTR_W-1:0]   r_out_attr, n_out_attr;

    logic [tcw_pkg::COL_W-1:0]  w_ec;
    logic [tcw_pkg::ROW_W-1:0]  w_er;
    logic [PROD_W-1:0]          w_size_prod;
    logic [tcw_pkg::COL_W-1:0]  w_loc_col;
    logic [tcw_pkg::ROW_W-1:0]  w_loc_row;
    logic [PROD_W-1:0]          w_loc_prod;
    logic [tcw_pkg::SIZE_W-1:0] w_loc;
    logic [tcw_pkg::SIZE_W-1:0] w_tab;
    logic [tcw_pkg::SIZE_W:0]   w_cur_pc;
    logic [tcw_pkg::SIZE_W:0]   w_idx_pc;
    logic [NL_W-1:0]            w_nl_prod;
    logic                       w_pos_big;
    logic                       w_rd_hit;
    logic                       w_accept;

    logic                       w_ram_we;
    logic [tcw_pkg::ADDR_W-1:0] w_ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] w_ram_wdata;
    logic [tcw_pkg::ADDR_W-1:0] w_ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] w_ram_rdata;
    logic [tcw_pkg::SIZE_W-1:0] w_waddr_ext;

    tcw_pkg::t_div_req w_div_req;
    tcw_pkg::t_div_rsp w_div_rsp;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::STORE_CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    tcw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == tcw_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_pos = r_out_cursor;
    assign o_out.cell_char  = r_out_char;
    assign o_out.cell_attr  = r_out_attr;

    // Register values out of range are pulled into 1..MAX.
    assign w_ec = (r_columns == '0) ? tcw_pkg::COL_W'(1) :
                  (32'(r_columns) > tcw_pkg::MAX_COLS) ? tcw_pkg::COL_W'(tcw_pkg::MAX_COLS) :
                  tcw_pkg::COL_W'(r_columns);
    assign w_er = (r_rows == '0) ? tcw_pkg::ROW_W'(1) :
                  (32'(r_rows) > tcw_pkg::MAX_ROWS) ? tcw_pkg::ROW_W'(tcw_pkg::MAX_ROWS) :
                  tcw_pkg::ROW_W'(r_rows);
    assign w_size_prod = PROD_W'(w_ec) * PROD_W'(w_er);

    assign w_loc_col  = (32'(r_col) >= 32'(w_ec)) ? w_ec - 1'b1 : tcw_pkg::COL_W'(r_col);
    assign w_loc_row  = (32'(r_row) >= 32'(w_er)) ? w_er - 1'b1 : tcw_pkg::ROW_W'(r_row);
    assign w_loc_prod = PROD_W'(w_loc_row) * PROD_W'(w_ec);
    assign w_loc      = tcw_pkg::SIZE_W'(w_loc_prod) + tcw_pkg::SIZE_W'(w_loc_col);

    assign w_tab = (r_cursor + tcw_pkg::SIZE_W'(tcw_pkg::TAB_WIDTH))
                 & ~tcw_pkg::SIZE_W'(tcw_pkg::TAB_WIDTH - 1);

    assign w_cur_pc = {1'b0, r_cursor} + (tcw_pkg::SIZE_W + 1)'(w_ec);
    assign w_idx_pc = {1'b0, r_idx} + (tcw_pkg::SIZE_W + 1)'(w_ec);
    assign w_nl_prod = (NL_W'(w_div_rsp.quot) + NL_W'(1)) * NL_W'(w_ec);

    assign w_pos_big = (32'(r_pos) >= 32'(r_size));
    assign w_rd_hit  = (32'(r_pos) < tcw_pkg::STORE_CELLS);
    assign w_waddr_ext = tcw_pkg::SIZE_W'(w_ram_waddr);

    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_attr       = r_attr;
        n_idx        = r_idx;
        n_rd_char    = r_rd_char;
        n_rd_attr    = r_rd_attr;
        n_out_valid  = r_out_valid;
        n_out_cursor = r_out_cursor;
        n_out_char   = r_out_char;
        n_out_attr   = r_out_attr;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_cursor[tcw_pkg::ADDR_W-1:0];
        w_ram_wdata  = {r_attr, r_char};
        w_ram_raddr  = tcw_pkg::ADDR_W'(r_pos);
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_cursor[tcw_pkg::ADDR_W-1:0];
        w_div_req.divisor  = w_ec;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_idx[tcw_pkg::ADDR_W-1:0];
                w_ram_wdata = tcw_pkg::BLANK_CELL;
                n_idx       = r_idx + 1'b1;
                if (r_idx == tcw_pkg::SIZE_W'(tcw_pkg::STORE_CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = tcw_pkg::ST_CLAMP;
                end
            end
            tcw_pkg::ST_CLAMP: begin
                // A cursor left beyond a shrunken screen is pulled back first.
                if (r_cursor >= r_size) begin
                    n_cursor = r_size - 1'b1;
                end
                n_state = tcw_pkg::ST_EXEC;
            end
            tcw_pkg::ST_EXEC: begin
                n_rd_char = '0;
                n_rd_attr = '0;
                n_state   = tcw_pkg::ST_DONE;
                case (r_cmd)
                    tcw_pkg::CMD_PUT: begin
                        n_state = tcw_pkg::ST_POST;
                        case (r_char)
                            tcw_pkg::CH_LF, tcw_pkg::CH_CR: begin
                                w_div_req.start = 1'b1;
                                n_state         = tcw_pkg::ST_DIV_WAIT;
                            end
                            tcw_pkg::CH_BS: begin
                                if (r_cursor != '0) begin
                                    n_cursor = r_cursor - 1'b1;
                                end
                            end
                            tcw_pkg::CH_TAB: begin
                                n_cursor = (w_tab >= r_size) ? r_size - 1'b1 : w_tab;
                            end
                            tcw_pkg::CH_VT: begin
                                if (w_cur_pc < {1'b0, r_size}) begin
                                    n_cursor = w_cur_pc[tcw_pkg::SIZE_W-1:0];
                                end
                            end
                            tcw_pkg::CH_FF: begin
                                n_cursor = '0;
                            end
                            tcw_pkg::CH_BEL: begin
                                n_cursor = r_cursor;
                            end
                            default: begin
                                w_ram_we = 1'b1;
                                n_cursor = r_cursor + 1'b1;
                            end
                        endcase
                    end
                    tcw_pkg::CMD_LOCATE: begin
                        n_cursor = w_loc;
                    end
                    tcw_pkg::CMD_SETPOS: begin
                        n_cursor = w_pos_big ? r_size - 1'b1 : tcw_pkg::SIZE_W'(r_pos);
                    end
                    tcw_pkg::CMD_SETATTR: begin
                        n_attr = r_attr_in;
                    end
                    tcw_pkg::CMD_READ: begin
                        if (w_rd_hit) begin
                            n_state = tcw_pkg::ST_RD_DATA;
                        end
                    end
                    default: begin
                        n_cursor = r_cursor;
                    end
                endcase
            end
            tcw_pkg::ST_RD_DATA: begin
                n_rd_char = w_ram_rdata[tcw_pkg::CHAR_W-1:0];
                n_rd_attr = w_ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                n_state   = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    // Newline: start of the next row. Carriage return: start of this row.
                    if (r_char == tcw_pkg::CH_LF) begin
                        n_cursor = tcw_pkg::SIZE_W'(w_nl_prod);
                    end else begin
                        n_cursor = r_cursor - tcw_pkg::SIZE_W'(w_div_rsp.rem);
                    end
                    n_state = tcw_pkg::ST_POST;
                end
            end
            tcw_pkg::ST_POST: begin
                if (r_cursor >= r_size) begin
                    n_idx   = '0;
                    n_state = tcw_pkg::ST_SC_RD;
                end else begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_SC_RD: begin
                if (w_idx_pc < {1'b0, r_size}) begin
                    w_ram_raddr = w_idx_pc[tcw_pkg::ADDR_W-1:0];
                    n_state     = tcw_pkg::ST_SC_WR;
                end else begin
                    n_state = tcw_pkg::ST_FILL;
                end
            end
            tcw_pkg::ST_SC_WR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_idx[tcw_pkg::ADDR_W-1:0];
                w_ram_wdata = w_ram_rdata;
                n_idx       = r_idx + 1'b1;
                n_state     = tcw_pkg::ST_SC_RD;
            end
            tcw_pkg::ST_FILL: begin
                if (r_idx < r_size) begin
                    w_ram_we    = 1'b1;
                    w_ram_waddr = r_idx[tcw_pkg::ADDR_W-1:0];
                    w_ram_wdata = {r_attr, tcw_pkg::SPACE_CHAR};
                    n_idx       = r_idx + 1'b1;
                end else begin
                    n_cursor = r_size - tcw_pkg::SIZE_W'(w_ec);
                    n_state  = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = tcw_pkg::CURSOR_W'(r_cursor);
                    n_out_char   = r_rd_char;
                    n_out_attr   = r_rd_attr;
                    n_state      = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_CLEAR;
            r_columns   <= tcw_pkg::RESET_COLS;
            r_rows      <= tcw_pkg::RESET_ROWS;
            r_size      <= tcw_pkg::SIZE_W'(32'(tcw_pkg::RESET_COLS) * 32'(tcw_pkg::RESET_ROWS));
            r_cursor    <= '0;
            r_attr      <= tcw_pkg::RESET_ATTR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= tcw_pkg::SIZE_W'(w_size_prod);
            r_cursor    <= n_cursor;
            r_attr      <= n_attr;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    tcw_pkg::REG_COLUMNS: r_columns <= i_cfg.data[tcw_pkg::CFG_COLS_W-1:0];
                    tcw_pkg::REG_ROWS:    r_rows    <= i_cfg.data[tcw_pkg::CFG_ROWS_W-1:0];
                    default: begin
                        r_rows <= r_rows;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_in.command;
            r_char    <= i_in.char_code;
            r_col     <= i_in.column;
            r_row     <= i_in.row;
            r_pos     <= i_in.position;
            r_attr_in <= i_in.attribute;
        end
        r_rd_char    <= n_rd_char;
        r_rd_attr    <= n_rd_attr;
        r_out_cursor <= n_out_cursor;
        r_out_char   <= n_out_char;
        r_out_attr   <= n_out_attr;
    end

    `TCW_ASSERT_NEXT(a_accept_starts_clamp, w_accept, r_state == tcw_pkg::ST_CLAMP, "accepted word did not start the sequencer")
    `TCW_ASSERT_NOW(a_no_write_when_idle, r_state == tcw_pkg::ST_IDLE, !w_ram_we, "store written while idle")
    `TCW_ASSERT_NOW(a_write_inside_screen, w_ram_we && (r_state != tcw_pkg::ST_CLEAR), w_waddr_ext < r_size, "store write outside the screen")
    `TCW_ASSERT_NOW(a_div_start_when_free, w_div_req.start, !w_div_rsp.busy, "divider started while busy")
    `TCW_ASSERT_NEXT(a_scroll_leaves_cursor, (r_state == tcw_pkg::ST_FILL) && (r_idx >= r_size), r_cursor < r_size, "cursor off screen after scroll")

endmodule
